// ===== rtl/core/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser package
// Shared types, event and error codes and sizing constants.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int unsigned MAX_DEPTH_DEF     = 16;
    localparam int unsigned LEN_BYTES_MAX_DEF = 4;

    localparam logic [4:0]  TAG_LONG_FORM  = 5'd31;
    localparam logic [7:0]  LEN_INDEF      = 8'h80;
    localparam logic [2:0]  TAG_MAX_CHUNKS = 3'd5;
    localparam logic [2:0]  TAG_LAST_CHUNK = 3'd4;
    localparam logic [31:0] OFFSET_MAX     = 32'hFFFF_FFFF;
    localparam logic [31:0] UNIV_BITSTRING = 32'd3;

    localparam logic [2:0] EV_HEADER  = 3'd0;
    localparam logic [2:0] EV_CONTENT = 3'd1;
    localparam logic [2:0] EV_BITS    = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNC     = 3'd1;
    localparam logic [2:0] ERR_TAG_BIG   = 3'd2;
    localparam logic [2:0] ERR_LEN_LONG  = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;
    localparam logic [2:0] ERR_EMPTY_BIT = 3'd5;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd6;

    typedef enum logic [2:0] {
        PH_IDENT,
        PH_TAGHI,
        PH_LEN0,
        PH_LENX,
        PH_BITS,
        PH_CONTENT,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_EMIT
    } t_eng_state;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_qitem;

    typedef struct packed {
        logic [2:0]  ev_res;
        logic [2:0]  err_code;
        logic [1:0]  tag_class;
        logic        constructed;
        logic [31:0] tag_number;
        logic        indefinite;
        logic [31:0] content_length;
        logic [4:0]  depth;
        logic [15:0] element_index;
        logic [7:0]  data_byte;
    } t_event;

    typedef struct packed {
        logic [31:0] end_off;
        logic        indef;
    } t_stk;

endpackage

// ===== rtl/core/btlv_front.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser front end
// Two-entry byte queue that decouples the input stream from the parse engine.
// ----------------------------------------------------------------------------
module btlv_front
    import btlv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    output logic   o_valid,
    input  logic   i_ready,
    output t_qitem o_item
);

    t_qitem     r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/core/btlv_engine.sv =====
// ----------------------------------------------------------------------------
// BER TLV parse engine
// Decodes one queued byte, walks the nesting stack on element completion and
// issues the resulting events through an output register.
// ----------------------------------------------------------------------------
module btlv_engine
    import btlv_pkg::*;
#(
    parameter int unsigned MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int unsigned LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qitem i_item,
    output logic   o_valid,
    input  logic   i_ready,
    output t_event o_event,
    output logic   o_top_done,
    output logic   o_last
);

    localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned LW = $clog2(LEN_BYTES_MAX + 1);

    t_stk        r_stack [MAX_DEPTH];
    t_stk        r_rd;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    t_stk        wr_data;

    t_eng_state  r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [31:0] r_tag, n_tag;
    logic [2:0]  r_tagcnt, n_tagcnt;
    logic [31:0] r_len, n_len;
    logic [LW-1:0] r_left, n_left;
    logic [31:0] r_off, n_off;
    logic [DW-1:0] r_depth, n_depth;
    logic [31:0] r_cend, n_cend;
    logic [2:0]  r_hbits, n_hbits;
    logic        r_eoc0, n_eoc0;
    logic [15:0] r_elem, n_elem;
    t_stk        r_top, n_top;

    t_event      r_prim, n_prim;
    logic        r_prim_v, n_prim_v;
    logic [DW-1:0] r_pops, n_pops;
    logic [DW-1:0] r_ev_depth, n_ev_depth;
    logic [2:0]  r_err, n_err;
    logic [DW-1:0] r_err_depth, n_err_depth;
    logic        r_fin, n_fin;
    logic        r_done, n_done;
    logic [DW-1:0] r_sc_d, n_sc_d;

    logic        r_out_v, n_out_v;
    t_event      r_out, n_out;
    logic        r_out_done, n_out_done;
    logic        r_out_last, n_out_last;

    logic [7:0]  b;
    logic [31:0] offn;
    logic        ti;
    logic        ovr;
    logic        do_lf;
    logic [2:0]  lf_hb;
    logic [31:0] lf_tag;
    logic        do_hd;
    logic [31:0] hd_len;
    logic [2:0]  hd_hb;
    logic [31:0] hd_tag;
    logic [32:0] end33;
    logic        hd_cons;
    logic        bitstr;
    logic        fail_v;
    logic [2:0]  fail_code;
    logic        need_fin;
    logic        do_clear;
    logic        out_free;
    logic        last;
    logic [15:0] idx;

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_v;
    assign o_event    = r_out;
    assign o_top_done = r_out_done;
    assign o_last     = r_out_last;
    assign out_free   = !r_out_v || i_ready;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_tag       = r_tag;
        n_tagcnt    = r_tagcnt;
        n_len       = r_len;
        n_left      = r_left;
        n_off       = r_off;
        n_depth     = r_depth;
        n_cend      = r_cend;
        n_hbits     = r_hbits;
        n_eoc0      = r_eoc0;
        n_elem      = r_elem;
        n_top       = r_top;
        n_prim      = r_prim;
        n_prim_v    = r_prim_v;
        n_pops      = r_pops;
        n_ev_depth  = r_ev_depth;
        n_err       = r_err;
        n_err_depth = r_err_depth;
        n_fin       = r_fin;
        n_done      = r_done;
        n_sc_d      = r_sc_d;
        n_out_v     = r_out_v && !i_ready;
        n_out       = r_out;
        n_out_done  = r_out_done;
        n_out_last  = r_out_last;
        rd_addr     = AW'(r_sc_d - DW'(1));
        wr_en       = 1'b0;
        wr_data     = '0;
        b           = i_item.data;
        offn        = r_off + 32'd1;
        ti          = (r_depth != '0) && r_top.indef;
        ovr         = (r_depth != '0) && !r_top.indef && (r_off >= r_top.end_off);
        do_lf       = 1'b0;
        lf_hb       = r_hbits;
        lf_tag      = r_tag;
        do_hd       = 1'b0;
        hd_len      = 32'd0;
        hd_hb       = r_hbits;
        hd_tag      = r_tag;
        end33       = '0;
        hd_cons     = 1'b0;
        bitstr      = 1'b0;
        fail_v      = 1'b0;
        fail_code   = ERR_NONE;
        need_fin    = 1'b0;
        do_clear    = 1'b0;
        last        = 1'b0;
        idx         = 16'd0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_fin    = i_item.fin;
                    n_done   = 1'b0;
                    n_pops   = '0;
                    n_err    = ERR_NONE;
                    n_prim_v = 1'b0;
                    n_prim   = '0;
                    if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
                        if (r_off == OFFSET_MAX) begin
                            fail_v    = 1'b1;
                            fail_code = ERR_LEN_LONG;
                        end else begin
                            n_off = offn;
                            case (r_phase)
                                PH_IDENT: begin
                                    if (ti && r_eoc0) begin
                                        n_eoc0 = 1'b0;
                                        if (b == 8'd0) begin
                                            n_depth            = r_depth - DW'(1);
                                            n_prim_v           = 1'b1;
                                            n_prim.ev_res      = EV_END;
                                            n_prim.constructed = 1'b1;
                                            n_prim.indefinite  = 1'b1;
                                            n_prim.depth       = 5'(r_depth - DW'(1));
                                            need_fin           = 1'b1;
                                        end else begin
                                            n_hbits = 3'd0;
                                            n_tag   = 32'd0;
                                            n_elem  = r_elem + 16'd1;
                                            lf_hb   = 3'd0;
                                            lf_tag  = 32'd0;
                                            do_lf   = 1'b1;
                                        end
                                    end else if (ti && b == 8'd0) begin
                                        n_eoc0 = 1'b1;
                                    end else begin
                                        n_hbits = b[7:5];
                                        n_elem  = r_elem + 16'd1;
                                        if (b[4:0] == TAG_LONG_FORM) begin
                                            n_tag    = 32'd0;
                                            n_tagcnt = 3'd0;
                                            n_phase  = PH_TAGHI;
                                        end else begin
                                            n_tag   = {27'd0, b[4:0]};
                                            n_phase = PH_LEN0;
                                        end
                                    end
                                end
                                PH_TAGHI: begin
                                    if (ovr) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_OVERRUN;
                                    end else if (r_tagcnt >= TAG_MAX_CHUNKS ||
                                                 (r_tagcnt == TAG_LAST_CHUNK &&
                                                  r_tag[31:25] != 7'd0)) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_TAG_BIG;
                                    end else begin
                                        n_tag    = {r_tag[24:0], b[6:0]};
                                        n_tagcnt = r_tagcnt + 3'd1;
                                        if (!b[7]) begin
                                            n_phase = PH_LEN0;
                                        end
                                    end
                                end
                                PH_LEN0: begin
                                    if (ovr) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_OVERRUN;
                                    end else begin
                                        do_lf = 1'b1;
                                    end
                                end
                                PH_LENX: begin
                                    if (ovr) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_OVERRUN;
                                    end else if (r_len[31:24] != 8'd0) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_LEN_LONG;
                                    end else begin
                                        n_len  = {r_len[23:0], b};
                                        n_left = r_left - LW'(1);
                                        if (r_left == LW'(1)) begin
                                            do_hd  = 1'b1;
                                            hd_len = {r_len[23:0], b};
                                        end
                                    end
                                end
                                PH_BITS, PH_CONTENT: begin
                                    n_prim_v              = 1'b1;
                                    n_prim.ev_res         = (r_phase == PH_BITS) ?
                                                            EV_BITS : EV_CONTENT;
                                    n_prim.tag_class      = r_hbits[2:1];
                                    n_prim.tag_number     = r_tag;
                                    n_prim.content_length = r_len;
                                    n_prim.depth          = 5'(r_depth);
                                    n_prim.element_index  = r_elem - 16'd1;
                                    n_prim.data_byte      = b;
                                    if (offn == r_cend) begin
                                        need_fin = 1'b1;
                                    end else begin
                                        n_phase = PH_CONTENT;
                                    end
                                end
                                default: begin
                                end
                            endcase

                            idx = n_elem - 16'd1;

                            // First length byte: indefinite, short or long form.
                            if (do_lf) begin
                                if (b == LEN_INDEF) begin
                                    if (r_depth >= DW'(MAX_DEPTH)) begin
                                        fail_v    = 1'b1;
                                        fail_code = ERR_TOO_DEEP;
                                    end else begin
                                        n_prim_v             = 1'b1;
                                        n_prim.ev_res        = EV_HEADER;
                                        n_prim.tag_class     = lf_hb[2:1];
                                        n_prim.constructed   = lf_hb[0];
                                        n_prim.tag_number    = lf_tag;
                                        n_prim.indefinite    = 1'b1;
                                        n_prim.depth         = 5'(r_depth);
                                        n_prim.element_index = idx;
                                        wr_en                = 1'b1;
                                        wr_data              = '{end_off: 32'd0, indef: 1'b1};
                                        n_top                = wr_data;
                                        n_depth              = r_depth + DW'(1);
                                        n_phase              = PH_IDENT;
                                        n_eoc0               = 1'b0;
                                    end
                                end else if (!b[7]) begin
                                    n_len  = {24'd0, b};
                                    do_hd  = 1'b1;
                                    hd_len = {24'd0, b};
                                    hd_hb  = lf_hb;
                                    hd_tag = lf_tag;
                                end else if ({1'b0, b[6:0]} > 8'(LEN_BYTES_MAX)) begin
                                    fail_v    = 1'b1;
                                    fail_code = ERR_LEN_LONG;
                                end else begin
                                    n_left  = LW'(b[6:0]);
                                    n_len   = 32'd0;
                                    n_phase = PH_LENX;
                                end
                            end

                            // Header complete: check bounds, then open or start content.
                            if (do_hd) begin
                                end33   = {1'b0, offn} + {1'b0, hd_len};
                                hd_cons = hd_hb[0];
                                bitstr  = (hd_hb == 3'd0) && (hd_tag == UNIV_BITSTRING);
                                if (end33[32]) begin
                                    fail_v    = 1'b1;
                                    fail_code = ERR_LEN_LONG;
                                end else if (r_depth != '0 && !r_top.indef &&
                                             end33[31:0] > r_top.end_off) begin
                                    fail_v    = 1'b1;
                                    fail_code = ERR_OVERRUN;
                                end else if (hd_cons && r_depth >= DW'(MAX_DEPTH)) begin
                                    fail_v    = 1'b1;
                                    fail_code = ERR_TOO_DEEP;
                                end else if (bitstr && hd_len == 32'd0) begin
                                    fail_v    = 1'b1;
                                    fail_code = ERR_EMPTY_BIT;
                                end else begin
                                    n_prim_v              = 1'b1;
                                    n_prim.ev_res         = EV_HEADER;
                                    n_prim.tag_class      = hd_hb[2:1];
                                    n_prim.constructed    = hd_cons;
                                    n_prim.tag_number     = hd_tag;
                                    n_prim.content_length = hd_len;
                                    n_prim.depth          = 5'(r_depth);
                                    n_prim.element_index  = idx;
                                    if (hd_cons) begin
                                        wr_en   = 1'b1;
                                        wr_data = '{end_off: end33[31:0], indef: 1'b0};
                                        n_top   = wr_data;
                                        n_depth = r_depth + DW'(1);
                                        n_phase = PH_IDENT;
                                        n_eoc0  = 1'b0;
                                    end else begin
                                        n_cend = end33[31:0];
                                        if (hd_len != 32'd0) begin
                                            n_phase = bitstr ? PH_BITS : PH_CONTENT;
                                        end
                                    end
                                    need_fin = (hd_len == 32'd0);
                                end
                            end
                        end

                        if (fail_v) begin
                            n_prim          = '0;
                            n_prim_v        = 1'b1;
                            n_prim.ev_res   = EV_ERROR;
                            n_prim.err_code = fail_code;
                            n_prim.depth    = 5'(r_depth);
                            n_phase         = PH_ERROR;
                            wr_en           = 1'b0;
                            n_depth         = r_depth;
                            need_fin        = 1'b0;
                        end

                        if (!need_fin && i_item.fin && n_phase != PH_ERROR &&
                            n_phase != PH_DONE) begin
                            n_err       = ERR_TRUNC;
                            n_err_depth = n_depth;
                        end
                    end

                    n_ev_depth = n_depth - DW'(1);
                    n_sc_d     = n_depth;
                    if (need_fin) begin
                        n_state = ST_SCAN_RD;
                    end else if (n_prim_v || n_err != ERR_NONE) begin
                        n_state = ST_EMIT;
                    end else begin
                        do_clear = i_item.fin;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (r_sc_d == '0) begin
                    n_depth = '0;
                    n_phase = PH_DONE;
                    n_done  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd.indef || r_off < r_rd.end_off) begin
                    n_depth = r_sc_d;
                    n_top   = r_rd;
                    n_phase = PH_IDENT;
                    n_eoc0  = 1'b0;
                    if (r_fin) begin
                        n_err       = ERR_TRUNC;
                        n_err_depth = r_sc_d;
                    end
                    n_state = ST_EMIT;
                end else if (r_off > r_rd.end_off) begin
                    n_depth     = r_sc_d;
                    n_phase     = PH_ERROR;
                    n_err       = ERR_OVERRUN;
                    n_err_depth = r_sc_d;
                    n_state     = ST_EMIT;
                end else begin
                    n_pops  = r_pops + DW'(1);
                    n_sc_d  = r_sc_d - DW'(1);
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = '0;
                    n_out_done = r_done;
                    if (r_prim_v) begin
                        n_out    = r_prim;
                        n_prim_v = 1'b0;
                        last     = (r_pops == '0) && (r_err == ERR_NONE);
                    end else if (r_pops != '0) begin
                        n_out.ev_res      = EV_END;
                        n_out.constructed = 1'b1;
                        n_out.depth       = 5'(r_ev_depth);
                        n_pops            = r_pops - DW'(1);
                        n_ev_depth        = r_ev_depth - DW'(1);
                        last              = (r_pops == DW'(1)) && (r_err == ERR_NONE);
                    end else begin
                        n_out.ev_res   = EV_ERROR;
                        n_out.err_code = r_err;
                        n_out.depth    = 5'(r_err_depth);
                        n_err          = ERR_NONE;
                        last           = 1'b1;
                    end
                    n_out_last = last;
                    if (last) begin
                        n_state  = ST_IDLE;
                        do_clear = r_fin;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // End of buffer: return to the post-reset state for the next one.
        if (do_clear) begin
            n_phase  = PH_IDENT;
            n_tag    = 32'd0;
            n_tagcnt = 3'd0;
            n_len    = 32'd0;
            n_left   = '0;
            n_off    = 32'd0;
            n_depth  = '0;
            n_cend   = 32'd0;
            n_hbits  = 3'd0;
            n_eoc0   = 1'b0;
            n_elem   = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_IDENT;
            r_tag    <= 32'd0;
            r_tagcnt <= 3'd0;
            r_len    <= 32'd0;
            r_left   <= '0;
            r_off    <= 32'd0;
            r_depth  <= '0;
            r_cend   <= 32'd0;
            r_hbits  <= 3'd0;
            r_eoc0   <= 1'b0;
            r_elem   <= 16'd0;
            r_prim_v <= 1'b0;
            r_pops   <= '0;
            r_err    <= ERR_NONE;
            r_fin    <= 1'b0;
            r_done   <= 1'b0;
            r_sc_d   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_tagcnt <= n_tagcnt;
            r_len    <= n_len;
            r_left   <= n_left;
            r_off    <= n_off;
            r_depth  <= n_depth;
            r_cend   <= n_cend;
            r_hbits  <= n_hbits;
            r_eoc0   <= n_eoc0;
            r_elem   <= n_elem;
            r_prim_v <= n_prim_v;
            r_pops   <= n_pops;
            r_err    <= n_err;
            r_fin    <= n_fin;
            r_done   <= n_done;
            r_sc_d   <= n_sc_d;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_prim      <= n_prim;
        r_ev_depth  <= n_ev_depth;
        r_err_depth <= n_err_depth;
        r_out       <= n_out;
        r_out_done  <= n_out_done;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[AW'(r_depth)] <= wr_data;
        end
        r_rd <= r_stack[rd_addr];
    end

endmodule

// ===== rtl/core/ber_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// BER TLV stream parser
// Event-stream decoder for ASN.1 BER/DER encoded buffers.
// ----------------------------------------------------------------------------
// Usage: bytes of an encoded buffer enter on the slave stream, one per
// request, with tlast marking the final byte of the buffer. Events leave on
// the master stream: tuser carries the event kind and tlast marks the last
// event caused by one input byte. A byte may cause no event at all.
// A byte is decoded once the engine is idle, and each event then passes
// through the output register. Bytes that complete an element walk the
// nesting stack, reading and then checking one level at a time, because the
// stack lives in a memory with a registered read port. The engine takes no
// new byte until it has issued every event of the last one; bytes queue in
// a two-entry buffer meanwhile.
// Reset clears all parse state; the stack memory needs no clearing because
// entries above the current depth are never read. After the final byte of a
// buffer the parser returns to the same state for the next buffer.
// When the receiver holds tready low the current event waits in the output
// register, the engine stops, and the input buffer fills and then stalls.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser
    import btlv_pkg::*;
#(
    parameter int unsigned MAX_DEPTH     = MAX_DEPTH_DEF,
    parameter int unsigned LEN_BYTES_MAX = LEN_BYTES_MAX_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // in_byte[7:0]
    input  logic         i_s_axis_tlast,   // final_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // error_code[2:0], tag_class[4:3], constructed[5], tag_number[37:6],
    // indefinite[38], content_length[70:39], depth[75:71],
    // element_index[91:76], data_byte[99:92], top_done[100], zero[103:101]
    output logic [103:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // event_res[2:0]
    output logic         o_m_axis_tlast    // last_in_run
);

    t_qitem q_in;
    t_qitem q_out;
    logic   q_valid;
    logic   q_ready;
    t_event ev;
    logic   ev_done;

    assign q_in = '{data: i_s_axis_tdata, fin: i_s_axis_tlast};

    btlv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_out)
    );

    btlv_engine #(
        .MAX_DEPTH     (MAX_DEPTH),
        .LEN_BYTES_MAX (LEN_BYTES_MAX)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .o_ready    (q_ready),
        .i_item     (q_out),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_event    (ev),
        .o_top_done (ev_done),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = ev.ev_res;
    assign o_m_axis_tdata = {3'd0, ev_done, ev.data_byte, ev.element_index, ev.depth,
                             ev.content_length, ev.indefinite, ev.tag_number,
                             ev.constructed, ev.tag_class, ev.err_code};

endmodule

// ===== rtl/core/btlv_checker.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser port checker
// Concurrent checks on the parser's ports, bound to the top level.
// ----------------------------------------------------------------------------
module btlv_checker
    import btlv_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [103:0] i_m_axis_tdata,
    input logic [2:0]   i_m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid)
        else $error("output event dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("event shown straight after reset");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> ((i_m_axis_tuser == EV_ERROR) ==
                             (i_m_axis_tdata[2:0] != ERR_NONE)))
        else $error("error code does not match event kind");

    a_end_cons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tuser == EV_END |-> i_m_axis_tdata[5])
        else $error("end event without constructed flag");

endmodule

bind ber_tlv_stream_parser btlv_checker u_btlv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

// ===== test/ber_tlv_stream_parser_tb.sv =====
// ----------------------------------------------------------------------------
// BER TLV stream parser testbench
// Feeds directed and randomly generated BER buffers into the parser, with
// random gaps on the byte stream and random stalls on the event stream.
// Every accepted byte is run through a behavioural decoder, and each event
// that leaves the parser is checked field by field against its prediction.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_tb;
    import btlv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned ITEM_GOAL   = 450;

    typedef logic [7:0] t_bq[$];

    // One pending request on the byte stream. A held byte is not offered
    // until every expected event has been seen.
    typedef struct {
        logic [7:0] data;
        logic       fin;
        logic       hold;
    } t_req;

    // One decoded event, in the order of the output fields.
    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  code;
        logic [1:0]  cls;
        logic        cons;
        logic [31:0] tag;
        logic        indef;
        logic [31:0] len;
        logic [4:0]  depth;
        logic [15:0] idx;
        logic [7:0]  data;
        logic        done;
        logic        last;
    } t_evt;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata;
    logic         i_s_axis_tlast;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [103:0] o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    ber_tlv_stream_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_req        byte_q[$];     // bytes still to be offered
    t_evt        event_q[$];    // events predicted but not yet seen
    t_evt        byte_events[$];
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    int unsigned sent_cnt;
    int unsigned recv_cnt;
    int unsigned send_gap;
    int unsigned recv_stall;

    // ------------------------------------------------------------------------
    // Clock and reset.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Behavioural decoder state.
    // ------------------------------------------------------------------------
    t_phase      dec_phase;
    logic [31:0] tag_acc;
    int unsigned chunk_cnt;
    logic [31:0] len_acc;
    int unsigned len_left;
    logic [31:0] pos;
    logic [31:0] end_stk [MAX_DEPTH_DEF];
    logic        indef_stk [MAX_DEPTH_DEF];
    int unsigned nest;
    logic [31:0] content_end;
    logic [2:0]  hdr_bits;
    logic        eoc_held;
    logic [15:0] elem_cnt;
    logic        top_done_now;

    task automatic clear_decoder();
        dec_phase = PH_IDENT;
        tag_acc   = '0;
        chunk_cnt = 0;
        len_acc   = '0;
        len_left  = 0;
        pos       = '0;
        nest      = 0;
        content_end = '0;
        hdr_bits  = '0;
        eoc_held  = 1'b0;
        elem_cnt  = '0;
        foreach (end_stk[i]) begin
            end_stk[i]   = '0;
            indef_stk[i] = 1'b0;
        end
    endtask

    task automatic add_event(logic [2:0] ev, logic [2:0] code, logic [1:0] cls, logic cons,
                             logic [31:0] tag, logic indef, logic [31:0] len,
                             logic [7:0] data, logic [15:0] idx);
        t_evt e;
        e.ev = ev; e.code = code; e.cls = cls; e.cons = cons; e.tag = tag;
        e.indef = indef; e.len = len; e.depth = nest[4:0]; e.idx = idx;
        e.data = data; e.done = 1'b0; e.last = 1'b0;
        byte_events.push_back(e);
    endtask

    task automatic raise_error(logic [2:0] code);
        add_event(EV_ERROR, code, 2'd0, 1'b0, '0, 1'b0, '0, 8'd0, 16'd0);
        dec_phase = PH_ERROR;
    endtask

    // An element has just completed: close the definite containers ending here.
    task automatic close_elements();
        int unsigned t;
        while (nest > 0) begin
            t = nest - 1;
            if (indef_stk[t]) break;
            if (pos > end_stk[t]) begin
                raise_error(ERR_OVERRUN);
                return;
            end
            if (pos < end_stk[t]) break;
            nest--;
            add_event(EV_END, ERR_NONE, 2'd0, 1'b1, '0, 1'b0, '0, 8'd0, 16'd0);
        end
        if (nest == 0) begin
            dec_phase    = PH_DONE;
            top_done_now = 1'b1;
        end else begin
            dec_phase = PH_IDENT;
            eoc_held  = 1'b0;
        end
    endtask

    // A header byte at or past the end of the enclosing definite element.
    task automatic check_overrun(input logic [31:0] p, output logic bad);
        bad = nest > 0 && !indef_stk[nest-1] && p >= end_stk[nest-1];
        if (bad) raise_error(ERR_OVERRUN);
    endtask

    task automatic open_element(logic [7:0] b);
        hdr_bits = b[7:5];
        tag_acc  = {27'd0, b[4:0]};
        elem_cnt = elem_cnt + 16'd1;
    endtask

    task automatic finish_header();
        logic [32:0] fin_pos;
        logic        is_bits;
        fin_pos = {1'b0, pos} + {1'b0, len_acc};
        is_bits = hdr_bits == 3'b000 && tag_acc == UNIV_BITSTRING;
        if (fin_pos[32]) begin
            raise_error(ERR_LEN_LONG);
        end else if (nest > 0 && !indef_stk[nest-1] && fin_pos[31:0] > end_stk[nest-1]) begin
            raise_error(ERR_OVERRUN);
        end else if (hdr_bits[0] && nest >= MAX_DEPTH_DEF) begin
            raise_error(ERR_TOO_DEEP);
        end else if (is_bits && len_acc == 0) begin
            raise_error(ERR_EMPTY_BIT);
        end else begin
            add_event(EV_HEADER, ERR_NONE, hdr_bits[2:1], hdr_bits[0], tag_acc, 1'b0,
                      len_acc, 8'd0, elem_cnt - 16'd1);
            if (hdr_bits[0]) begin
                end_stk[nest]   = fin_pos[31:0];
                indef_stk[nest] = 1'b0;
                nest++;
                dec_phase = PH_IDENT;
                eoc_held  = 1'b0;
                if (len_acc == 0) close_elements();
            end else begin
                content_end = fin_pos[31:0];
                if (len_acc == 0) close_elements();
                else dec_phase = is_bits ? PH_BITS : PH_CONTENT;
            end
        end
    endtask

    task automatic first_length_byte(logic [7:0] b);
        if (b == LEN_INDEF) begin
            if (nest >= MAX_DEPTH_DEF) begin
                raise_error(ERR_TOO_DEEP);
            end else begin
                add_event(EV_HEADER, ERR_NONE, hdr_bits[2:1], hdr_bits[0], tag_acc, 1'b1,
                          '0, 8'd0, elem_cnt - 16'd1);
                end_stk[nest]   = '0;
                indef_stk[nest] = 1'b1;
                nest++;
                dec_phase = PH_IDENT;
                eoc_held  = 1'b0;
            end
        end else if (!b[7]) begin
            len_acc = {24'd0, b};
            finish_header();
        end else if (b[6:0] > LEN_BYTES_MAX_DEF) begin
            raise_error(ERR_LEN_LONG);
        end else begin
            len_left  = b[6:0];
            len_acc   = '0;
            dec_phase = PH_LENX;
        end
    endtask

    // Decode one accepted byte and queue the events it causes.
    task automatic decode_byte(logic [7:0] b, logic fin);
        logic [31:0] p;
        logic        bad;
        logic        in_indef;
        byte_events.delete();
        top_done_now = 1'b0;
        if (dec_phase != PH_DONE && dec_phase != PH_ERROR) begin
            p = pos;
            if (p == OFFSET_MAX) begin
                raise_error(ERR_LEN_LONG);
            end else begin
                pos = p + 32'd1;
                case (dec_phase)
                    PH_IDENT: begin
                        in_indef = nest > 0 && indef_stk[nest-1];
                        if (in_indef && eoc_held) begin
                            // A held zero: a second zero closes the container,
                            // anything else makes it a tag-0 identifier.
                            eoc_held = 1'b0;
                            if (b == 8'd0) begin
                                nest--;
                                add_event(EV_END, ERR_NONE, 2'd0, 1'b1, '0, 1'b1, '0,
                                          8'd0, 16'd0);
                                close_elements();
                            end else begin
                                open_element(8'd0);
                                first_length_byte(b);
                            end
                        end else if (in_indef && b == 8'd0) begin
                            eoc_held = 1'b1;
                        end else begin
                            open_element(b);
                            if (b[4:0] == TAG_LONG_FORM) begin
                                tag_acc   = '0;
                                chunk_cnt = 0;
                                dec_phase = PH_TAGHI;
                            end else begin
                                dec_phase = PH_LEN0;
                            end
                        end
                    end
                    PH_TAGHI: begin
                        check_overrun(p, bad);
                        if (!bad) begin
                            if (chunk_cnt >= TAG_MAX_CHUNKS ||
                                (chunk_cnt == TAG_LAST_CHUNK && tag_acc[31:25] != 0)) begin
                                raise_error(ERR_TAG_BIG);
                            end else begin
                                tag_acc = {tag_acc[24:0], b[6:0]};
                                chunk_cnt++;
                                if (!b[7]) dec_phase = PH_LEN0;
                            end
                        end
                    end
                    PH_LEN0: begin
                        check_overrun(p, bad);
                        if (!bad) first_length_byte(b);
                    end
                    PH_LENX: begin
                        check_overrun(p, bad);
                        if (!bad) begin
                            if (len_acc[31:24] != 0) begin
                                raise_error(ERR_LEN_LONG);
                            end else begin
                                len_acc = {len_acc[23:0], b};
                                len_left--;
                                if (len_left == 0) finish_header();
                            end
                        end
                    end
                    PH_BITS, PH_CONTENT: begin
                        add_event(dec_phase == PH_BITS ? EV_BITS : EV_CONTENT, ERR_NONE,
                                  hdr_bits[2:1], 1'b0, tag_acc, 1'b0, len_acc, b,
                                  elem_cnt - 16'd1);
                        if (pos == content_end) close_elements();
                        else dec_phase = PH_CONTENT;
                    end
                    default: ;
                endcase
            end
        end
        if (fin && dec_phase != PH_DONE && dec_phase != PH_ERROR) raise_error(ERR_TRUNC);
        foreach (byte_events[k]) begin
            byte_events[k].done = top_done_now;
            byte_events[k].last = (k == byte_events.size() - 1);
            event_q.push_back(byte_events[k]);
        end
        if (fin) clear_decoder();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------------
    int unsigned queued_cnt;

    task automatic add_buffer(t_bq bytes, logic hold);
        t_req r;
        foreach (bytes[i]) begin
            r.data = bytes[i];
            r.fin  = (i == bytes.size() - 1);
            r.hold = hold && i == 0;
            byte_q.push_back(r);
        end
        queued_cnt += bytes.size();
    endtask

    // A random well-formed element, possibly with nested children.
    function automatic t_bq random_element(int unsigned lvl);
        t_bq         body;
        t_bq         r;
        t_bq         child;
        logic [1:0]  cls;
        logic        cons;
        logic        indef;
        logic [31:0] tag;
        int unsigned n;
        int unsigned sel;
        cls   = $urandom_range(0, 3);
        cons  = lvl < 4 && $urandom_range(0, 2) == 0;
        indef = cons && $urandom_range(0, 2) == 0;
        sel   = $urandom_range(0, 9);
        if (sel < 7)      tag = $urandom_range(0, 30);
        else if (sel < 9) tag = $urandom_range(31, 20000);
        else              tag = $urandom;
        if (cons) begin
            n = $urandom_range(0, 3);
            repeat (n) begin
                child = random_element(lvl + 1);
                body  = {body, child};
            end
        end else begin
            // A universal bit string starts with its unused-bits count.
            if (cls == 2'd0 && tag == UNIV_BITSTRING) body.push_back($urandom_range(0, 7));
            repeat ($urandom_range(0, 6)) body.push_back($urandom);
        end
        if (tag < 31) begin
            r.push_back({cls, cons, tag[4:0]});
        end else begin
            r.push_back({cls, cons, TAG_LONG_FORM});
            for (int s = 28; s > 0; s -= 7)
                if ((tag >> s) != 0) r.push_back({1'b1, 7'(tag >> s)});
            r.push_back({1'b0, tag[6:0]});
        end
        if (indef) begin
            r.push_back(LEN_INDEF);
            r = {r, body};
            r.push_back(8'h00);
            r.push_back(8'h00);
        end else begin
            n = body.size();
            if (n < 128 && $urandom_range(0, 3) != 0) begin
                r.push_back(n[7:0]);
            end else if (n < 256) begin
                r.push_back(8'h81);
                r.push_back(n[7:0]);
            end else begin
                r.push_back(8'h82);
                r.push_back(n[15:8]);
                r.push_back(n[7:0]);
            end
            r = {r, body};
        end
        return r;
    endfunction

    initial begin
        t_bq         buf_q;
        int unsigned sel;
        int unsigned next_hold;
        queued_cnt = 0;
        clear_decoder();

        // Directed buffers.
        add_buffer('{8'h30, 8'h03, 8'h02, 8'h01, 8'h05}, 1'b0);
        // Five-chunk tag with a small first chunk, zero length.
        add_buffer('{8'h1F, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00}, 1'b0);
        // Five chunks that overflow 32 bits, and six chunks.
        add_buffer('{8'h1F, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00}, 1'b0);
        add_buffer('{8'h1F, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h01, 8'h00}, 1'b0);
        // Too many length bytes, and an end past the largest offset.
        add_buffer('{8'h04, 8'h85, 8'h00}, 1'b0);
        add_buffer('{8'h04, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
        // Indefinite sequence closed by an end marker.
        add_buffer('{8'h30, 8'h80, 8'h02, 8'h01, 8'h07, 8'h00, 8'h00}, 1'b0);
        // Indefinite constructed string; a held zero that turns into a tag-0 element.
        add_buffer('{8'h24, 8'h80, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00}, 1'b0);
        // Bit string with unused bits, and an empty bit string.
        add_buffer('{8'h03, 8'h02, 8'h06, 8'hC0}, 1'b0);
        add_buffer('{8'h03, 8'h00}, 1'b0);
        // Child longer than its parent.
        add_buffer('{8'h30, 8'h02, 8'h04, 8'h03, 8'h11, 8'h22, 8'h33}, 1'b0);
        // Indefinite child that closes past, then exactly at, the end of its definite parent.
        add_buffer('{8'h30, 8'h03, 8'h30, 8'h80, 8'h00, 8'h00}, 1'b0);
        add_buffer('{8'h30, 8'h04, 8'h30, 8'h80, 8'h00, 8'h00}, 1'b0);
        // Truncated buffer, then trailing bytes after a complete element.
        add_buffer('{8'h30, 8'h05, 8'h02}, 1'b0);
        add_buffer('{8'h02, 8'h01, 8'h7F, 8'hFF, 8'hFF}, 1'b0);
        // Private class with a long tag, context class with a long length.
        add_buffer('{8'hDF, 8'h7F, 8'h00}, 1'b0);
        add_buffer('{8'hA1, 8'h81, 8'h03, 8'h02, 8'h01, 8'h00}, 1'b0);
        add_buffer('{8'h30, 8'h00}, 1'b0);
        add_buffer('{8'h30, 8'h80, 8'h30, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
        add_buffer('{8'hFF}, 1'b0);
        // Seventeen nested indefinite containers: one too many.
        buf_q.delete();
        repeat (MAX_DEPTH_DEF + 1) begin
            buf_q.push_back(8'h30);
            buf_q.push_back(LEN_INDEF);
        end
        add_buffer(buf_q, 1'b1);

        // Random buffers: mostly well formed, some damaged, some noise.
        next_hold = queued_cnt + 100;
        while (queued_cnt < ITEM_GOAL) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                buf_q.delete();
                repeat ($urandom_range(1, 6)) buf_q.push_back($urandom);
            end else begin
                buf_q = random_element(0);
                if (sel < 20) begin
                    buf_q = buf_q[0:$urandom_range(0, buf_q.size() - 1)];
                end else if (sel < 30) begin
                    buf_q[$urandom_range(0, buf_q.size() - 1)] = $urandom;
                end else if (sel < 45) begin
                    repeat ($urandom_range(1, 3)) buf_q.push_back($urandom);
                end
            end
            add_buffer(buf_q, queued_cnt >= next_hold);
            if (queued_cnt >= next_hold) next_hold = queued_cnt + 150;
        end

        // Drain: all bytes taken, all events seen, then a short settle.
        wait (i_rst_n && byte_q.size() == 0 && !i_s_axis_tvalid);
        wait (event_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("ber_tlv_stream_parser regression: pass");
        end else begin
            $display("ber_tlv_stream_parser regression: fail");
        end
        $finish;
    end

    // Gap lengths: mostly none or short, a few long; every fourth block of
    // 64 requests runs with no gaps at all.
    function automatic int unsigned random_gap(int unsigned cnt);
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((cnt / 64) % 4 == 1) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Byte stream driver.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic offer;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tlast  <= 1'b0;
            send_gap        <= 0;
            sent_cnt        <= 0;
        end else begin
            offer = 1'b0;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_byte(byte_q[0].data, byte_q[0].fin);
                byte_q.pop_front();
                sent_cnt <= sent_cnt + 1;
                send_gap <= random_gap(sent_cnt);
            end else if (i_s_axis_tvalid) begin
                offer = 1'b1;
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (byte_q.size() > 0 && !(byte_q[0].hold && event_q.size() > 0)) begin
                offer = 1'b1;
            end
            // A byte just accepted is followed directly only if no gap is due.
            if (i_s_axis_tvalid && o_s_axis_tready && byte_q.size() > 0 &&
                random_gap(sent_cnt) == 0 && !byte_q[0].hold)
                offer = 1'b1;
            i_s_axis_tvalid <= offer;
            if (offer) begin
                i_s_axis_tdata <= byte_q[0].data;
                i_s_axis_tlast <= byte_q[0].fin;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event stream monitor, with random back-pressure.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_evt got;
        t_evt want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_stall      <= 0;
            recv_cnt        <= 0;
            fail_cnt        <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tuser, o_m_axis_tdata[2:0], o_m_axis_tdata[4:3],
                       o_m_axis_tdata[5], o_m_axis_tdata[37:6], o_m_axis_tdata[38],
                       o_m_axis_tdata[70:39], o_m_axis_tdata[75:71], o_m_axis_tdata[91:76],
                       o_m_axis_tdata[99:92], o_m_axis_tdata[100], o_m_axis_tlast};
                recv_cnt <= recv_cnt + 1;
                if (event_q.size() == 0) begin
                    $display("%0t: unexpected event: expected none, got %p", $time, got);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = event_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: event mismatch: expected %p, got %p", $time, want, got);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall      <= recv_stall - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                recv_stall      <= random_gap(recv_cnt + 32);
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("ber_tlv_stream_parser regression: fail");
            $finish;
        end
    end

endmodule
